FILE: rtl/core/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the packed image stream decoder.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int DIM_BITS = 16;

	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_HDR_OK = 2'd1,
		KIND_HDR_BAD = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_TYPE  = 3'd1,
		ERR_RED   = 3'd2,
		ERR_GREEN = 3'd3,
		ERR_BLUE  = 3'd4,
		ERR_SIZE  = 3'd5
	} err_t;

	typedef struct packed {
		kind_t       kind;
		err_t        error_code;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] column;
		logic [15:0] row;
		logic        is_color;
		logic        last_in_byte;
		logic        last_of_image;
	} result_t;

	// results produced by one byte, in order
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage
`default_nettype wire

FILE: rtl/core/psd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_core
// Header parser and nibble unpacker; computes the results of one byte and
// updates the decoder state when the byte is consumed.
// ----------------------------------------------------------------------------
module psd_core import psd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] byte_s1,
	output push_t           push
);

	localparam logic [3:0] PH_TYPE   = 4'd0;
	localparam logic [3:0] PH_RED    = 4'd1;
	localparam logic [3:0] PH_GREEN  = 4'd2;
	localparam logic [3:0] PH_BLUE   = 4'd3;
	localparam logic [3:0] PH_WLAST  = 4'd7;
	localparam logic [3:0] PH_HLAST  = 4'd11;
	localparam logic [3:0] PH_PIXEL  = 4'd12;

	localparam logic [1:0] CH_RED    = 2'd0;
	localparam logic [1:0] CH_GREEN  = 2'd1;
	localparam logic [1:0] CH_BLUE   = 2'd2;

	localparam logic [2:0] WCODE_BAD = 3'd4;

	localparam logic [7:0] TYPE_COLOR = 8'hFF;
	localparam logic [7:0] TYPE_GREY  = 8'h00;

	localparam logic [31:0] DIM_MAX = 32'((64'd1 << DIM_BITS) - 64'd1);

	typedef struct packed {
		logic [15:0]         acc;
		logic [1:0]          held;
		logic [1:0]          chan;
		logic [15:0]         hred;
		logic [15:0]         hgreen;
		logic [DIM_BITS-1:0] col;
		logic [DIM_BITS-1:0] row;
		logic                active;
	} pix_t;

	typedef struct packed {
		pix_t    st;
		logic    emit;
		result_t res;
	} step_t;

	logic [3:0]          phase_q, phase_n;
	logic                color_q, color_n;
	logic [1:0]          rcode_q, rcode_n;
	logic [1:0]          gcode_q, gcode_n;
	logic [1:0]          bcode_q, bcode_n;
	logic [31:0]         size_q, size_n;
	logic [DIM_BITS-1:0] width_q, width_n;
	logic [DIM_BITS-1:0] height_q, height_n;
	pix_t                pix_q, pix_n;

	logic [31:0] sv_next;
	logic        sv_ok;
	logic [2:0]  wcode;
	pix_t        pix_in;
	step_t       p0, p1;

	function automatic logic [2:0] width_code(input logic [7:0] b);
		logic [2:0] c;
		unique case (b)
			8'd4:    c = 3'd0;
			8'd8:    c = 3'd1;
			8'd12:   c = 3'd2;
			8'd16:   c = 3'd3;
			default: c = WCODE_BAD;
		endcase
		return c;
	endfunction

	function automatic logic [15:0] scale16(input logic [15:0] v, input logic [1:0] code);
		logic [15:0] s;
		unique case (code)
			2'd0:    s = {v[3:0], v[3:0], v[3:0], v[3:0]};
			2'd1:    s = {v[7:0], v[7:0]};
			2'd2:    s = {v[11:0], 4'h0};
			default: s = v;
		endcase
		return s;
	endfunction

	function automatic step_t nib_step(input pix_t s, input logic [3:0] nib,
			input logic color, input logic [1:0] cr, input logic [1:0] cg,
			input logic [1:0] cb, input logic [DIM_BITS-1:0] w,
			input logic [DIM_BITS-1:0] h);
		step_t         o;
		logic [1:0]    code;
		logic [15:0]   acc;
		logic [15:0]   value;
		logic          col_wrap;
		logic          row_wrap;
		logic          last;
		o = '0;
		o.st = s;
		if (!color || s.chan == CH_RED) begin
			code = cr;
		end else if (s.chan == CH_GREEN) begin
			code = cg;
		end else begin
			code = cb;
		end
		acc = {s.acc[11:0], nib};
		value = scale16(acc, code);
		col_wrap = ({1'b0, s.col} + (DIM_BITS + 1)'(1)) >= {1'b0, w};
		row_wrap = ({1'b0, s.row} + (DIM_BITS + 1)'(1)) >= {1'b0, h};
		last = col_wrap && row_wrap;
		if (s.active) begin
			if (s.held < code) begin
				o.st.acc = acc;
				o.st.held = s.held + 2'd1;
			end else begin
				o.st.acc = '0;
				o.st.held = '0;
				if (color && s.chan == CH_RED) begin
					o.st.hred = value;
					o.st.chan = CH_GREEN;
				end else if (color && s.chan == CH_GREEN) begin
					o.st.hgreen = value;
					o.st.chan = CH_BLUE;
				end else begin
					o.emit = 1'b1;
					o.res.kind = KIND_PIXEL;
					o.res.error_code = ERR_NONE;
					o.res.red = color ? s.hred : value;
					o.res.green = color ? s.hgreen : value;
					o.res.blue = value;
					o.res.column = 16'(s.col);
					o.res.row = 16'(s.row);
					o.res.is_color = color;
					o.res.last_of_image = last;
					o.st.chan = CH_RED;
					if (last) begin
						o.st.active = 1'b0;
						o.st.col = '0;
						o.st.row = '0;
					end else if (col_wrap) begin
						o.st.col = '0;
						o.st.row = s.row + DIM_BITS'(1);
					end else begin
						o.st.col = s.col + DIM_BITS'(1);
					end
				end
			end
		end
		return o;
	endfunction

	always_comb begin
		sv_next = {size_q[23:0], byte_s1};
		sv_ok = (sv_next != 32'd0) && (sv_next <= DIM_MAX);
		wcode = width_code(byte_s1);
		pix_in = pix_q;
		pix_in.active = (phase_q == PH_PIXEL);
		p0 = nib_step(pix_in, byte_s1[7:4], color_q, rcode_q, gcode_q, bcode_q,
			width_q, height_q);
		p1 = nib_step(p0.st, byte_s1[3:0], color_q, rcode_q, gcode_q, bcode_q,
			width_q, height_q);
	end

	always_comb begin
		phase_n = phase_q;
		color_n = color_q;
		rcode_n = rcode_q;
		gcode_n = gcode_q;
		bcode_n = bcode_q;
		size_n = size_q;
		width_n = width_q;
		height_n = height_q;
		pix_n = pix_q;
		push = '0;
		priority if (phase_q == PH_TYPE) begin
			if (byte_s1 == TYPE_COLOR) begin
				color_n = 1'b1;
				phase_n = PH_RED;
			end else if (byte_s1 == TYPE_GREY) begin
				color_n = 1'b0;
				phase_n = PH_RED;
			end else begin
				push.n = 2'd1;
				push.r0.kind = KIND_HDR_BAD;
				push.r0.error_code = ERR_TYPE;
				push.r0.last_in_byte = 1'b1;
			end
		end else if (phase_q <= PH_BLUE) begin
			if (wcode == WCODE_BAD) begin
				phase_n = PH_TYPE;
				push.n = 2'd1;
				push.r0.kind = KIND_HDR_BAD;
				push.r0.last_in_byte = 1'b1;
				unique case (phase_q)
					PH_RED:   push.r0.error_code = ERR_RED;
					PH_GREEN: push.r0.error_code = ERR_GREEN;
					default:  push.r0.error_code = ERR_BLUE;
				endcase
			end else begin
				unique case (phase_q)
					PH_RED:   rcode_n = wcode[1:0];
					PH_GREEN: gcode_n = wcode[1:0];
					default:  bcode_n = wcode[1:0];
				endcase
				phase_n = phase_q + 4'd1;
			end
		end else if (phase_q < PH_PIXEL) begin
			size_n = sv_next;
			if (phase_q == PH_WLAST) begin
				width_n = sv_ok ? sv_next[DIM_BITS-1:0] : '0;
				phase_n = phase_q + 4'd1;
			end else if (phase_q == PH_HLAST) begin
				push.n = 2'd1;
				push.r0.last_in_byte = 1'b1;
				if (width_q == '0 || !sv_ok) begin
					phase_n = PH_TYPE;
					push.r0.kind = KIND_HDR_BAD;
					push.r0.error_code = ERR_SIZE;
				end else begin
					height_n = sv_next[DIM_BITS-1:0];
					pix_n = '0;
					phase_n = PH_PIXEL;
					push.r0.kind = KIND_HDR_OK;
					push.r0.is_color = color_q;
				end
			end else begin
				phase_n = phase_q + 4'd1;
			end
		end else begin
			pix_n = p1.st;
			if (phase_q == PH_PIXEL && !p1.st.active) begin
				phase_n = PH_TYPE;
			end
			if (p0.emit && p1.emit) begin
				push.n = 2'd2;
				push.r0 = p0.res;
				push.r1 = p1.res;
				push.r1.last_in_byte = 1'b1;
			end else if (p0.emit) begin
				push.n = 2'd1;
				push.r0 = p0.res;
				push.r0.last_in_byte = 1'b1;
			end else if (p1.emit) begin
				push.n = 2'd1;
				push.r0 = p1.res;
				push.r0.last_in_byte = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			color_q <= 1'b0;
			rcode_q <= '0;
			gcode_q <= '0;
			bcode_q <= '0;
			size_q <= '0;
			width_q <= '0;
			height_q <= '0;
			pix_q <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			color_q <= color_n;
			rcode_q <= rcode_n;
			gcode_q <= gcode_n;
			bcode_q <= bcode_n;
			size_q <= size_n;
			width_q <= width_n;
			height_q <= height_n;
			pix_q <= pix_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/psd_obuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_obuf
// Two-entry result buffer; takes up to two results per cycle and presents
// one per transfer on the output channel.
// ----------------------------------------------------------------------------
module psd_obuf import psd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  fire,
	input  wire push_t push,
	input  wire logic  out_ready,
	output logic       out_valid,
	output result_t    head,
	output logic [1:0] room
);

	result_t    slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic [1:0] rem;
	logic [1:0] add;

	assign out_valid = (cnt_q != 2'd0);
	assign head = slot0_q;
	assign pop = out_valid && out_ready;
	assign rem = cnt_q - {1'b0, pop};
	assign room = 2'd2 - rem;
	assign add = fire ? push.n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= rem + add;
		end
	end

	always_ff @(posedge clk) begin
		if (rem == 2'd0) begin
			slot0_q <= push.r0;
			slot1_q <= push.r1;
		end else if (rem == 2'd1) begin
			slot0_q <= pop ? slot1_q : slot0_q;
			slot1_q <= push.r0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/packed_image_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_image_stream_decoder
// Parses a 12-byte image header and unpacks nibble-packed pixels.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the result buffer has room; a result
// passes through the input register and the result buffer before it is
// presented. Each byte is decoded combinationally between the input
// register and a two-entry result buffer. Output is one result per cycle
// while out_ready is high, so a byte yielding two results (two 4-bit grey
// pixels) holds the input until the buffer has room for both.
// ----------------------------------------------------------------------------
module packed_image_stream_decoder import psd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [2:0]       error_code,
	output logic [15:0]      red,
	output logic [15:0]      green,
	output logic [15:0]      blue,
	output logic [15:0]      column,
	output logic [15:0]      row,
	output logic             is_color,
	output logic             last_in_byte,
	output logic             last_of_image
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire;
	logic [1:0] room;
	push_t      push;
	result_t    head;

	assign fire = valid_s1 && (push.n <= room);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	psd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.push    (push)
	);

	psd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.push      (push),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	assign kind = head.kind;
	assign error_code = head.error_code;
	assign red = head.red;
	assign green = head.green;
	assign blue = head.blue;
	assign column = head.column;
	assign row = head.row;
	assign is_color = head.is_color;
	assign last_in_byte = head.last_in_byte;
	assign last_of_image = head.last_of_image;

endmodule
`default_nettype wire

FILE: tb/psd_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_stream_checker
// Watches both channels of the packed image stream decoder. Every byte
// transfer is decoded by a local header parser and pixel unpacker. The
// results it yields are queued, and each result transfer is compared field
// by field with the oldest queued one.
// ----------------------------------------------------------------------------
module psd_stream_checker import psd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [2:0]  error_code,
	input  wire logic [15:0] red,
	input  wire logic [15:0] green,
	input  wire logic [15:0] blue,
	input  wire logic [15:0] column,
	input  wire logic [15:0] row,
	input  wire logic        is_color,
	input  wire logic        last_in_byte,
	input  wire logic        last_of_image,
	output int               failures,
	output int               pending
);

	localparam logic [3:0] PH_TYPE       = 4'd0;
	localparam logic [3:0] PH_RED_W      = 4'd1;
	localparam logic [3:0] PH_GREEN_W    = 4'd2;
	localparam logic [3:0] PH_BLUE_W     = 4'd3;
	localparam logic [3:0] PH_WIDTH_END  = 4'd7;
	localparam logic [3:0] PH_HEIGHT_END = 4'd11;
	localparam logic [3:0] PH_PIXELS     = 4'd12;
	localparam logic [31:0] DIM_MAX = (32'd1 << DIM_BITS) - 32'd1;

	logic [3:0]  phase;
	logic        color;
	logic [1:0]  rcode, gcode, bcode;
	logic [31:0] size_sr;
	logic [15:0] img_w, img_h, col_cnt, row_cnt, acc;
	logic [1:0]  nib_cnt, chan;
	logic [15:0] hold_r, hold_g;

	result_t decoded_q[$];
	int miss_count = 0;
	int result_idx = 0;

	task automatic report(input string field, input int got, input int want);
		miss_count++;
		$display("%0t ns: result %0d: %s mismatch, got %0d expected %0d",
			$time, result_idx, field, got, want);
	endtask

	task automatic decode_byte(input logic [7:0] b);
		result_t res[2];
		int n;
		int k;
		logic [3:0] nib;
		logic [1:0] code;
		logic [2:0] wcode;
		logic [15:0] value;
		logic last_px;
		n = 0;
		res[0] = '0;
		res[1] = '0;
		if (phase == PH_TYPE) begin
			if (b == 8'hFF) begin
				color = 1'b1;
				phase = PH_RED_W;
			end else if (b == 8'h00) begin
				color = 1'b0;
				phase = PH_RED_W;
			end else begin
				res[0].kind = KIND_HDR_BAD;
				res[0].error_code = ERR_TYPE;
				n = 1;
			end
		end else if (phase <= PH_BLUE_W) begin
			case (b)
				8'd4: wcode = 3'd0;
				8'd8: wcode = 3'd1;
				8'd12: wcode = 3'd2;
				8'd16: wcode = 3'd3;
				default: wcode = 3'd4;
			endcase
			if (wcode[2]) begin
				res[0].kind = KIND_HDR_BAD;
				case (phase)
					PH_RED_W: res[0].error_code = ERR_RED;
					PH_GREEN_W: res[0].error_code = ERR_GREEN;
					default: res[0].error_code = ERR_BLUE;
				endcase
				n = 1;
				phase = PH_TYPE;
			end else begin
				case (phase)
					PH_RED_W: rcode = wcode[1:0];
					PH_GREEN_W: gcode = wcode[1:0];
					default: bcode = wcode[1:0];
				endcase
				phase++;
			end
		end else if (phase < PH_PIXELS) begin
			size_sr = {size_sr[23:0], b};
			if (phase == PH_WIDTH_END) begin
				img_w = (size_sr >= 32'd1 && size_sr <= DIM_MAX) ? size_sr[15:0] : 16'd0;
				phase++;
			end else if (phase == PH_HEIGHT_END) begin
				if (img_w == 16'd0 || size_sr < 32'd1 || size_sr > DIM_MAX) begin
					res[0].kind = KIND_HDR_BAD;
					res[0].error_code = ERR_SIZE;
					phase = PH_TYPE;
				end else begin
					img_h = size_sr[15:0];
					col_cnt = '0;
					row_cnt = '0;
					acc = '0;
					nib_cnt = '0;
					chan = '0;
					hold_r = '0;
					hold_g = '0;
					phase = PH_PIXELS;
					res[0].kind = KIND_HDR_OK;
					res[0].error_code = ERR_NONE;
					res[0].is_color = color;
				end
				n = 1;
			end else begin
				phase++;
			end
		end else begin
			for (k = 0; k < 2; k++) begin
				if (phase == PH_PIXELS) begin
					nib = (k == 0) ? b[7:4] : b[3:0];
					if (!color || chan == 2'd0)
						code = rcode;
					else if (chan == 2'd1)
						code = gcode;
					else
						code = bcode;
					acc = {acc[11:0], nib};
					if (nib_cnt < code) begin
						nib_cnt++;
					end else begin
						case (code)
							2'd0: value = acc[3:0] * 16'd4369;
							2'd1: value = acc[7:0] * 16'd257;
							2'd2: value = {acc[11:0], 4'h0};
							default: value = acc;
						endcase
						acc = '0;
						nib_cnt = '0;
						if (color && chan == 2'd0) begin
							hold_r = value;
							chan = 2'd1;
						end else if (color && chan == 2'd1) begin
							hold_g = value;
							chan = 2'd2;
						end else begin
							last_px = ({1'b0, col_cnt} + 17'd1 >= {1'b0, img_w}) &&
								({1'b0, row_cnt} + 17'd1 >= {1'b0, img_h});
							res[n].kind = KIND_PIXEL;
							res[n].error_code = ERR_NONE;
							res[n].red = color ? hold_r : value;
							res[n].green = color ? hold_g : value;
							res[n].blue = value;
							res[n].column = col_cnt;
							res[n].row = row_cnt;
							res[n].is_color = color;
							res[n].last_of_image = last_px;
							n++;
							chan = 2'd0;
							if (last_px) begin
								phase = PH_TYPE;
								col_cnt = '0;
								row_cnt = '0;
							end else begin
								col_cnt++;
								if (col_cnt >= img_w) begin
									col_cnt = '0;
									row_cnt++;
								end
							end
						end
					end
				end
			end
		end
		if (n > 0)
			res[n - 1].last_in_byte = 1'b1;
		for (k = 0; k < n; k++)
			decoded_q.push_back(res[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			phase = PH_TYPE;
			color = 1'b0;
			rcode = '0;
			gcode = '0;
			bcode = '0;
			size_sr = '0;
			img_w = '0;
			img_h = '0;
			col_cnt = '0;
			row_cnt = '0;
			acc = '0;
			nib_cnt = '0;
			chan = '0;
			hold_r = '0;
			hold_g = '0;
			decoded_q.delete();
			failures <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				decode_byte(data_byte);
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					report("unexpected result, kind", kind, 0);
				end else begin
					want = decoded_q.pop_front();
					if (kind !== want.kind) report("kind", kind, want.kind);
					if (error_code !== want.error_code)
						report("error_code", error_code, want.error_code);
					if (red !== want.red) report("red", red, want.red);
					if (green !== want.green) report("green", green, want.green);
					if (blue !== want.blue) report("blue", blue, want.blue);
					if (column !== want.column) report("column", column, want.column);
					if (row !== want.row) report("row", row, want.row);
					if (is_color !== want.is_color)
						report("is_color", is_color, want.is_color);
					if (last_in_byte !== want.last_in_byte)
						report("last_in_byte", last_in_byte, want.last_in_byte);
					if (last_of_image !== want.last_of_image)
						report("last_of_image", last_of_image, want.last_of_image);
				end
				result_idx++;
			end
			failures <= miss_count;
			pending <= decoded_q.size();
		end
	end

endmodule

FILE: tb/tb_packed_image_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_image_stream_decoder
// Feeds the decoder directed header errors and a tiny image, then random
// images of every channel width mix, broken headers, bad sizes and junk
// bytes, with random idle bursts on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_packed_image_stream_decoder;
	import psd_pkg::*;

	localparam int ITEMS       = 1050;
	localparam int CALM_TAIL   = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT     = 300;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        out_ready = 1'b0;
	logic        in_ready, out_valid;
	logic [1:0]  kind;
	logic [2:0]  error_code;
	logic [15:0] red, green, blue, column, row;
	logic        is_color, last_in_byte, last_of_image;

	int failures, pending;
	int sent = 0;
	int cycles = 0;
	bit tail = 1'b0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit hold_done = 1'b0;

	always #4 clk = ~clk;

	packed_image_stream_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .error_code(error_code),
		.red(red), .green(green), .blue(blue),
		.column(column), .row(row), .is_color(is_color),
		.last_in_byte(last_in_byte), .last_of_image(last_of_image)
	);

	psd_stream_checker stream_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .error_code(error_code),
		.red(red), .green(green), .blue(blue),
		.column(column), .row(row), .is_color(is_color),
		.last_in_byte(last_in_byte), .last_of_image(last_of_image),
		.failures(failures), .pending(pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_packed_image_stream_decoder NOT OK");
			$finish;
		end
	end

	function automatic logic [7:0] bad_type_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 254)); while (b == 8'h00 || b == 8'hFF);
		return b;
	endfunction

	function automatic logic [7:0] bad_width_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == 8'd4 || b == 8'd8 || b == 8'd12 || b == 8'd16);
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!tail && !tx_calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		if ($urandom_range(0, 199) == 0)
			tx_calm = !tx_calm;
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic send_header(input bit col, input logic [1:0] rc, gc, bc,
			input logic [31:0] w, h);
		int i;
		send_byte(col ? 8'hFF : 8'h00);
		send_byte({4'b0, rc, 2'b00} + 8'd4);
		send_byte({4'b0, gc, 2'b00} + 8'd4);
		send_byte({4'b0, bc, 2'b00} + 8'd4);
		for (i = 3; i >= 0; i--)
			send_byte(w[8 * i +: 8]);
		for (i = 3; i >= 0; i--)
			send_byte(h[8 * i +: 8]);
	endtask

	// fill < 0 gives random pixel bytes
	task automatic send_image(input bit col, input logic [1:0] rc, gc, bc,
			input int w, h, input int fill);
		int npp;
		int nbytes;
		int i;
		send_header(col, rc, gc, bc, w, h);
		npp = col ? (rc + gc + bc + 3) : (rc + 1);
		nbytes = (w * h * npp + 1) / 2;
		for (i = 0; i < nbytes; i++)
			send_byte(fill < 0 ? 8'($urandom_range(0, 255)) : fill[7:0]);
	endtask

	initial begin
		int stall;
		stall = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && sent >= HOLD_AT) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if ($urandom_range(0, 199) == 0)
				rx_calm = !rx_calm;
			if (stall == 0 && !tail && !rx_calm && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 10);
			out_ready <= (stall == 0);
			if (stall > 0)
				stall--;
		end
	end

	initial begin
		int sel;
		int pos;
		int i;
		bit col;
		logic [31:0] w, h;

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// header errors at each field, then one byte holding two grey pixels
		send_byte(8'h5A);
		send_byte(8'h00);
		send_byte(8'h03);
		send_byte(8'hFF);
		send_byte(8'd4);
		send_byte(8'd5);
		send_byte(8'hFF);
		send_byte(8'd8);
		send_byte(8'd12);
		send_byte(8'hFF);
		send_image(1'b0, 2'd0, 2'd0, 2'd0, 2, 1, 8'hF0);

		while (sent < ITEMS) begin
			if (sent >= ITEMS - CALM_TAIL)
				tail = 1'b1;
			sel = $urandom_range(0, 99);
			col = $urandom_range(0, 1);
			if (sel < 75) begin
				send_image(col, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)), $urandom_range(1, 6),
					$urandom_range(1, 4), -1);
			end else if (sel < 85) begin
				case ($urandom_range(0, 3))
					0: begin
						w = 32'd0;
						h = $urandom_range(1, 5);
					end
					1: begin
						w = 32'h0001_0000 | ($urandom() & 32'hFFFF_0000);
						h = 32'd1;
					end
					2: begin
						w = 32'd65535;
						h = 32'd0;
					end
					default: begin
						w = 32'd1;
						h = $urandom() | 32'h0001_0000;
					end
				endcase
				send_header(col, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)), w, h);
			end else if (sel < 93) begin
				pos = $urandom_range(0, 3);
				if (pos == 0) begin
					send_byte(bad_type_byte());
				end else begin
					send_byte(col ? 8'hFF : 8'h00);
					for (i = 1; i < pos; i++)
						send_byte(8'd4 * 8'($urandom_range(1, 4)));
					send_byte(bad_width_byte());
				end
			end else begin
				repeat ($urandom_range(1, 3)) send_byte(bad_type_byte());
			end
		end

		@(negedge clk) in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("tb_packed_image_stream_decoder OK");
		else
			$display("tb_packed_image_stream_decoder NOT OK");
		$finish;
	end

endmodule
